>>> design/cac_pkg.sv
// Shared types and constants for the set-associative cache core.
package cac_pkg;

    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int LAT_W  = 16;
    localparam int CFG_W  = 16;

    typedef enum logic [2:0] {
        REG_POLICY    = 3'd0,
        REG_SET_BITS  = 3'd1,
        REG_OFF_BITS  = 3'd2,
        REG_WAYS      = 3'd3,
        REG_HIT_LAT   = 3'd4,
        REG_MISS_LAT  = 3'd5
    } cac_reg_idx_t;

    typedef enum logic {
        POL_LRU = 1'b0,
        POL_LFU = 1'b1
    } cac_policy_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } cac_bk_state_t;

    typedef struct packed {
        cac_policy_t        policy;
        logic [2:0]         set_index_bits;
        logic [4:0]         offset_bits;
        logic [3:0]         ways_in_use;
        logic [LAT_W-1:0]   hit_latency;
        logic [LAT_W-1:0]   miss_latency;
    } cac_cfg_t;

    typedef struct packed {
        logic               hit;
        logic [LAT_W-1:0]   latency;
        logic [2:0]         way;
        logic               evicted;
    } cac_res_t;

    typedef struct packed {
        logic clearing;
        logic pop;
        logic push;
    } cac_bk_stat_t;

endpackage

>>> design/cac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> design/cac_fifo.sv
// Small register-based FIFO used between the stages and at the result side.
module cac_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = store_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (32'(wp_reg) == DEPTH - 1) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (32'(rp_reg) == DEPTH - 1) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wp_reg] <= wdata;
        end
    end
endmodule

>>> design/cac_front.sv
// Front end: splits an address into tag and set index for the lookup queue.
module cac_front #(
    parameter int MAX_SETS   = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  cac_pkg::cac_cfg_t                              cfg,
    input  logic [ADDR_WIDTH-1:0]                          address,
    output logic [ADDR_WIDTH-1:0]                          tag,
    output logic [$clog2(MAX_SETS > 1 ? MAX_SETS : 2)-1:0] set_idx
);
    import cac_pkg::*;

    localparam int SET_W = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);

    logic [5:0]            shift;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [7:0]            mask;
    logic [6:0]            raw_idx;
    logic [6:0]            red;

    assign shift   = 6'(cfg.set_index_bits) + 6'(cfg.offset_bits);
    assign tag     = address >> shift;
    assign shifted = address >> cfg.offset_bits;
    assign mask    = (8'd1 << cfg.set_index_bits) - 8'd1;
    assign raw_idx = 7'(shifted) & mask[6:0];

    // reduce the index modulo the set count, one shifted compare a step
    always_comb
    begin
        red = raw_idx;
        for (int k = 6; k >= 0; k--)
        begin
            if (32'(red) >= (MAX_SETS << k))
            begin
                red = red - 7'(MAX_SETS << k);
            end
        end
    end

    assign set_idx = SET_W'(red);
endmodule

>>> design/cac_back.sv
// Back end: RAM clear after reset, set read, tag match, replacement choice and write-back.
module cac_back #(
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  cac_pkg::cac_cfg_t                              cfg,
    input  logic                                           q_empty,
    input  logic [ADDR_WIDTH-1:0]                          q_tag,
    input  logic [$clog2(MAX_SETS > 1 ? MAX_SETS : 2)-1:0] q_set,
    input  logic                                           out_full,
    output cac_pkg::cac_res_t                              res,
    output cac_pkg::cac_bk_stat_t                          stat
);
    import cac_pkg::*;

    localparam int SET_W    = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
    localparam int WAY_W    = $clog2(MAX_WAYS > 1 ? MAX_WAYS : 2);
    localparam int WAY_BITS = 1 + ADDR_WIDTH + TIME_W + CNT_W;
    localparam int ROW_W    = MAX_WAYS * WAY_BITS;

    cac_bk_state_t         state_reg, state_next;
    logic [SET_W-1:0]      clr_reg, clr_next;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [TIME_W-1:0]     time_reg, time_next;

    logic                  ram_we, ram_re;
    logic [SET_W-1:0]      ram_wa;
    logic [ROW_W-1:0]      ram_wd, ram_rd, new_row;

    logic                  v   [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] t   [MAX_WAYS];
    logic [TIME_W-1:0]     ts  [MAX_WAYS];
    logic [CNT_W-1:0]      uc  [MAX_WAYS];
    logic [CNT_W-1:0]      key [MAX_WAYS];

    logic [5:0]            nw;
    logic                  hit_f, inv_f;
    logic [WAY_W-1:0]      hit_w, inv_w, vic_w, pick;
    logic [CNT_W-1:0]      best;
    logic [LAT_W-1:0]      lat;
    logic [WAY_BITS-1:0]   new_way;

    cac_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (q_set),
        .rd_data (ram_rd)
    );

    // unpack the row: {count, time, tag, valid} per way
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            v[w]   = ram_rd[w*WAY_BITS];
            t[w]   = ram_rd[w*WAY_BITS+1 +: ADDR_WIDTH];
            ts[w]  = ram_rd[w*WAY_BITS+1+ADDR_WIDTH +: TIME_W];
            uc[w]  = ram_rd[w*WAY_BITS+1+ADDR_WIDTH+TIME_W +: CNT_W];
            key[w] = (cfg.policy == POL_LRU) ? ts[w] : uc[w];
        end
    end

    always_comb
    begin
        if (cfg.ways_in_use == '0)
        begin
            nw = 6'd1;
        end
        else if (6'(cfg.ways_in_use) > 6'(MAX_WAYS))
        begin
            nw = 6'(MAX_WAYS);
        end
        else
        begin
            nw = 6'(cfg.ways_in_use);
        end
    end

    // lookup and victim choice, lowest way wins
    always_comb
    begin
        hit_f = 1'b0;
        inv_f = 1'b0;
        hit_w = '0;
        inv_w = '0;
        vic_w = '0;
        best  = key[0];
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (6'(w) < nw)
            begin
                if (v[w] && t[w] == tag_reg)
                begin
                    hit_f = 1'b1;
                    hit_w = WAY_W'(w);
                end
                if (!v[w])
                begin
                    inv_f = 1'b1;
                    inv_w = WAY_W'(w);
                end
            end
        end
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (6'(w) < nw && key[w] < best)
            begin
                best  = key[w];
                vic_w = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        pick = hit_f ? hit_w : (inv_f ? inv_w : vic_w);
        lat  = hit_f ? cfg.hit_latency : cfg.miss_latency;
        if (hit_f)
        begin
            new_way = {uc[pick] + 1'b1, time_reg, t[pick], 1'b1};
        end
        else
        begin
            new_way = {CNT_W'(1), time_reg, tag_reg, 1'b1};
        end
        new_row = ram_rd;
        new_row[32'(pick)*WAY_BITS +: WAY_BITS] = new_way;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_SETS - 1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty && !out_full)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        ram_wa        = set_reg;
        ram_wd        = new_row;
        stat.clearing = 1'b0;
        stat.pop      = 1'b0;
        stat.push     = 1'b0;
        time_next     = time_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                stat.clearing = 1'b1;
                ram_we        = 1'b1;
                ram_wa        = clr_reg;
                ram_wd        = '0;
            end
            BK_IDLE:
            begin
                stat.pop = !q_empty && !out_full;
                ram_re   = stat.pop;
            end
            BK_EXEC:
            begin
                ram_we    = 1'b1;
                stat.push = 1'b1;
                time_next = time_reg + TIME_W'(lat);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign res.hit     = hit_f;
    assign res.latency = lat;
    assign res.way     = 3'(pick);
    assign res.evicted = !hit_f && !inv_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            time_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            time_reg  <= time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.pop)
        begin
            tag_reg <= q_tag;
            set_reg <= q_set;
        end
    end
endmodule

>>> design/set_assoc_cache_lru_lfu_core.sv
// Top level of the set-associative read cache core with LRU/LFU replacement.
// Each address pushed in gives one result: hit flag, latency, way and eviction
// flag, in order. The front end splits the address into tag and set and hands
// it through a two-entry queue to the back end, which reads the whole set row
// from a single RAM, matches all ways in parallel and writes the row back the
// next cycle, taking a new lookup only after that. Results wait in a two-entry
// output queue, so new lookups continue while the consumer stalls until that
// queue is full. After reset the back end clears the RAM one set per cycle;
// full stays high during that sweep. Configuration writes via
// cfg_we/cfg_index/cfg_data take effect at once and must only be made when idle.
module set_assoc_cache_lru_lfu_core #(
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [ADDR_WIDTH-1:0] address,
    output logic                  empty,
    input  logic                  pop,
    output logic                  hit,
    output logic [15:0]           latency,
    output logic [2:0]            way,
    output logic                  evicted
);
    import cac_pkg::*;

    localparam int SET_W = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
    localparam int Q_W   = ADDR_WIDTH + SET_W;
    localparam int RES_W = $bits(cac_res_t);

    cac_cfg_t              cfg_reg;
    logic [ADDR_WIDTH-1:0] fe_tag, q_tag;
    logic [SET_W-1:0]      fe_set, q_set;
    logic                  q_full, q_empty, out_full;
    cac_res_t              bk_res, out_res;
    cac_bk_stat_t          bk_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy         <= POL_LRU;
            cfg_reg.set_index_bits <= 3'd6;
            cfg_reg.offset_bits    <= 5'd4;
            cfg_reg.ways_in_use    <= 4'd8;
            cfg_reg.hit_latency    <= 16'd1;
            cfg_reg.miss_latency   <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY:   cfg_reg.policy         <= cac_policy_t'(cfg_data[0]);
                REG_SET_BITS: cfg_reg.set_index_bits <= cfg_data[2:0];
                REG_OFF_BITS: cfg_reg.offset_bits    <= cfg_data[4:0];
                REG_WAYS:     cfg_reg.ways_in_use    <= cfg_data[3:0];
                REG_HIT_LAT:  cfg_reg.hit_latency    <= cfg_data;
                REG_MISS_LAT: cfg_reg.miss_latency   <= cfg_data;
                default:      cfg_reg.policy         <= cfg_reg.policy;
            endcase
        end
    end

    cac_front #(.MAX_SETS(MAX_SETS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .cfg     (cfg_reg),
        .address (address),
        .tag     (fe_tag),
        .set_idx (fe_set)
    );

    // lookup queue between front and back; no transfer during the clear sweep
    assign full = q_full || bk_stat.clearing;

    cac_fifo #(.WIDTH(Q_W), .DEPTH(2)) u_lookup_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push && !bk_stat.clearing),
        .wdata ({fe_tag, fe_set}),
        .full  (q_full),
        .rd    (bk_stat.pop),
        .rdata ({q_tag, q_set}),
        .empty (q_empty)
    );

    cac_back #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_tag    (q_tag),
        .q_set    (q_set),
        .out_full (out_full),
        .res      (bk_res),
        .stat     (bk_stat)
    );

    // result queue
    cac_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (bk_stat.push),
        .wdata (bk_res),
        .full  (out_full),
        .rd    (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign hit     = out_res.hit;
    assign latency = out_res.latency;
    assign way     = out_res.way;
    assign evicted = out_res.evicted;

    // a result is only produced for a lookup taken the cycle before
    a_push_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.push |-> $past(bk_stat.pop))
        else $error("result without lookup");

    // one lookup at a time in the back end
    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.pop |=> !bk_stat.pop)
        else $error("back-to-back lookups");

    // never a result transfer into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.push |-> !out_full)
        else $error("result queue overflow");

    // input held off while clearing
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> (full && !bk_stat.pop))
        else $error("lookup during clear");
endmodule
